[rtl/core/mpi_pkg.sv]
package mpi_pkg;

   // field widths of one segment entry and of the time base
   localparam int DUR_W  = 32;
   localparam int POS_W  = 48;
   localparam int VEL_W  = 32;
   localparam int ACC_W  = 32;
   localparam int TIME_W = 40;
   localparam int ENTRY_W = DUR_W + POS_W + VEL_W + ACC_W;

   // request kinds
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // register indexes on the csr port
   localparam logic [1:0] REG_TIME_STEP = 2'd0;
   localparam logic [1:0] REG_X_COUNT   = 2'd1;
   localparam logic [1:0] REG_Z_COUNT   = 2'd2;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      DP_IDLE,
      DP_DECODE,
      DP_WRITE,
      DP_SUM_CLR,
      DP_SUM_RD,
      DP_SUM_ACC,
      DP_XADV,
      DP_XRD,
      DP_XADD,
      DP_ZADV,
      DP_ZRD,
      DP_ZADD,
      DP_EV_RD,
      DP_EV_START,
      DP_EV_D,
      DP_EV_M1,
      DP_EV_M2,
      DP_EV_M3,
      DP_EV_M4,
      DP_EV_M5,
      DP_EV_RES,
      DP_FINISH
   } dp_step_type;

   typedef struct packed {
      dp_step_type step;
      logic        sel;       // axis under evaluation: 0 x, 1 z
   } ctrl_cmd_type;

   typedef struct packed {
      logic       req_new;    // request taken at this edge
      logic [1:0] cmd;
      logic       run_active;
      logic       adv_x;
      logic       x_last;
      logic       adv_z;
      logic       sum_last;
      logic       out_free;
   } dp_status_type;

endpackage

[rtl/core/motion_profile_interpolator.sv]
// Two-axis trajectory interpolator, piecewise constant acceleration.
// Request channel (req_): tuser carries the kind (load, start, tick) and
// the axis; tdata a segment slot and its duration, position, velocity and
// acceleration. A load writes one slot of the X or Z table, a start sums
// both tables' durations and restarts time at zero, a tick in a run
// samples both axes and returns one result on the rsp_ channel; tlast
// marks the final tick of a run. Requests are taken one at a time:
// req_tready is high only while the block is idle.
// A start reads both tables slot by slot to sum the durations; a tick
// first moves each axis past the segments it has finished, then
// evaluates X and then Z. Both axes share one 32x32 multiplier.
// The result stays in an output register until taken; if it is still
// waiting when the next tick completes, the block holds that tick until
// rsp_tready frees the register. Configuration goes through the csr_ port.
// Reset clears the run state and loads the register defaults; table
// contents are undefined until loaded.
module motion_profile_interpolator
   import mpi_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // seg_index, seg_duration, seg_position, seg_velocity, seg_accel, pad
   input  logic [151:0] req_tdata,
   // cmd, axis
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // time_now, pos_x, pos_z, vel_x, vel_z, acc_x, acc_z
   output logic [255:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [31:0]   time_step_ff;
   logic [4:0]    x_count_ff, z_count_ff;
   logic          csr_wr, req_accept;
   ctrl_cmd_type  ctl_cmd;
   dp_status_type dp_sts;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 32'd1311;
         x_count_ff   <= 5'd4;
         z_count_ff   <= 5'd4;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_TIME_STEP: time_step_ff <= csr_pwdata;
            REG_X_COUNT:   x_count_ff   <= csr_pwdata[4:0];
            REG_Z_COUNT:   z_count_ff   <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_TIME_STEP: csr_prdata = time_step_ff;
         REG_X_COUNT:   csr_prdata = {27'b0, x_count_ff};
         REG_Z_COUNT:   csr_prdata = {27'b0, z_count_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // request handshake
   assign req_tready = (ctl_cmd.step == DP_IDLE);
   assign req_accept = req_tvalid && req_tready;

   mpi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (dp_sts),
      .cmd   (ctl_cmd)
   );

   mpi_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctl_cmd),
      .sts        (dp_sts),
      .req_accept (req_accept),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .time_step  (time_step_ff),
      .x_count    (x_count_ff),
      .z_count    (z_count_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // a request always leaves the idle state for decode
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("ready stayed high after an accepted request");

   // a finished tick with a free output register always presents a result
   a_finish_presents: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.step == DP_FINISH && dp_sts.out_free) |=> rsp_tvalid)
      else $error("finished tick did not present a result");

   // the final tick of a run closes the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_tvalid) && rsp_tlast) |-> !dp_sts.run_active)
      else $error("run still active after its last tick");
`endif

endmodule

[rtl/core/mpi_ram.sv]
module mpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/mpi_ctrl.sv]
module mpi_ctrl
   import mpi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_WRITE,
      S_SUM_CLR, S_SUM_RD, S_SUM_ACC,
      S_XADV, S_XRD, S_XADD, S_ZADV, S_ZRD, S_ZADD,
      S_EV_RD, S_EV_START, S_EV_D,
      S_EV_M1, S_EV_M2, S_EV_M3, S_EV_M4, S_EV_M5, S_EV_RES,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      sel_ff;

   // sequencing of load, start and tick requests
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (sts.req_new) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               priority if (sts.cmd == CMD_LOAD) begin
                  state_ff <= S_WRITE;
               end else if (sts.cmd == CMD_START) begin
                  state_ff <= S_SUM_CLR;
               end else if (sts.cmd == CMD_TICK && sts.run_active) begin
                  state_ff <= S_XADV;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_WRITE:    state_ff <= S_IDLE;
            S_SUM_CLR:  state_ff <= S_SUM_RD;
            S_SUM_RD:   state_ff <= S_SUM_ACC;
            S_SUM_ACC:  state_ff <= sts.sum_last ? S_IDLE : S_SUM_RD;
            S_XADV: begin
               priority if (sts.adv_x && !sts.x_last) begin
                  state_ff <= S_XRD;
               end else if (sts.adv_x) begin
                  state_ff <= S_XADV;
               end else begin
                  state_ff <= S_ZADV;
               end
            end
            S_XRD:      state_ff <= S_XADD;
            S_XADD:     state_ff <= S_XADV;
            S_ZADV: begin
               if (sts.adv_z) begin
                  state_ff <= S_ZRD;
               end else begin
                  state_ff <= S_EV_RD;
                  sel_ff   <= 1'b0;
               end
            end
            S_ZRD:      state_ff <= S_ZADD;
            S_ZADD:     state_ff <= S_ZADV;
            S_EV_RD:    state_ff <= S_EV_START;
            S_EV_START: state_ff <= S_EV_D;
            S_EV_D:     state_ff <= S_EV_M1;
            S_EV_M1:    state_ff <= S_EV_M2;
            S_EV_M2:    state_ff <= S_EV_M3;
            S_EV_M3:    state_ff <= S_EV_M4;
            S_EV_M4:    state_ff <= S_EV_M5;
            S_EV_M5:    state_ff <= S_EV_RES;
            S_EV_RES: begin
               if (sel_ff) begin
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_EV_RD;
                  sel_ff   <= 1'b1;
               end
            end
            S_FINISH: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath operation for each state
   always_comb begin
      cmd.sel = sel_ff;
      unique case (state_ff)
         S_IDLE:     cmd.step = DP_IDLE;
         S_DECODE:   cmd.step = DP_DECODE;
         S_WRITE:    cmd.step = DP_WRITE;
         S_SUM_CLR:  cmd.step = DP_SUM_CLR;
         S_SUM_RD:   cmd.step = DP_SUM_RD;
         S_SUM_ACC:  cmd.step = DP_SUM_ACC;
         S_XADV:     cmd.step = DP_XADV;
         S_XRD:      cmd.step = DP_XRD;
         S_XADD:     cmd.step = DP_XADD;
         S_ZADV:     cmd.step = DP_ZADV;
         S_ZRD:      cmd.step = DP_ZRD;
         S_ZADD:     cmd.step = DP_ZADD;
         S_EV_RD:    cmd.step = DP_EV_RD;
         S_EV_START: cmd.step = DP_EV_START;
         S_EV_D:     cmd.step = DP_EV_D;
         S_EV_M1:    cmd.step = DP_EV_M1;
         S_EV_M2:    cmd.step = DP_EV_M2;
         S_EV_M3:    cmd.step = DP_EV_M3;
         S_EV_M4:    cmd.step = DP_EV_M4;
         S_EV_M5:    cmd.step = DP_EV_M5;
         S_EV_RES:   cmd.step = DP_EV_RES;
         S_FINISH:   cmd.step = DP_FINISH;
         default:    cmd.step = DP_IDLE;
      endcase
   end

endmodule

[rtl/core/mpi_dp.sv]
module mpi_dp
   import mpi_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type sts,
   input  logic          req_accept,
   input  logic [151:0]  req_tdata,
   input  logic [2:0]    req_tuser,
   input  logic [31:0]   time_step,
   input  logic [4:0]    x_count,
   input  logic [4:0]    z_count,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [255:0]  rsp_tdata,
   output logic          rsp_tlast
);

   localparam int IW   = $clog2(MAX_SEGMENTS);
   localparam int CW0  = $clog2(MAX_SEGMENTS + 1);
   localparam int CNTW = (CW0 > 5) ? CW0 : 5;
   localparam int LW   = (IW > 4) ? IW : 4;
   localparam int SW   = 98;   // position sum, 21 fraction bits
   localparam int VW   = 66;   // velocity sum, 16 fraction bits

   // captured request
   logic [1:0]       in_cmd_ff;
   logic             in_axis_ff;
   logic [3:0]       in_idx_ff;
   logic [ENTRY_W-1:0] in_entry_ff;

   // run state
   logic [TIME_W-1:0] run_time_ff, x_total_ff, z_total_ff, x_seg_end_ff, z_seg_end_ff;
   logic [IW-1:0]     x_seg_now_ff, z_seg_now_ff;
   logic              x_holding_ff, run_active_ff, rsp_valid_ff;
   logic [CNTW-1:0]   cnt_ff;

   // evaluation registers
   logic [TIME_W-1:0] start_ff, t_ff;
   logic [31:0]       d_ff;
   logic [63:0]       prod_ff, ad_ff;
   logic [SW-1:0]     sum_ff;
   logic [VW-1:0]     vsum_ff;
   logic [POS_W-1:0]  e_pos_ff, px_ff, pz_ff;
   logic [VEL_W-1:0]  e_v_ff, vx_ff, vz_ff;
   logic [ACC_W-1:0]  e_a_ff, ax_ff, az_ff;

   // result register
   logic [31:0]       o_time_ff;
   logic [POS_W-1:0]  o_px_ff, o_pz_ff;
   logic [VEL_W-1:0]  o_vx_ff, o_vz_ff;
   logic [ACC_W-1:0]  o_ax_ff, o_az_ff;
   logic              o_last_ff;

   logic [CNTW-1:0]    xc, zc, cx, cz, sum_n;
   logic [LW-1:0]      idx_lw;
   logic               idx_ok, we_x, we_z, out_free, last_in;
   logic [IW-1:0]      raddr_x, raddr_z;
   logic [ENTRY_W-1:0] rd_x, rd_z, rd_sel;
   logic [TIME_W:0]    next_in;
   logic [TIME_W-1:0]  se_in, dur_sel, diff_in;
   logic [31:0]        mul_a, v_mag, a_mag;
   logic [SW-1:0]      sum_rnd;
   logic [VW-1:0]      vsum_rnd;
   logic [POS_W-1:0]   pos_sat;
   logic [VEL_W-1:0]   vel_sat;

   function automatic logic [31:0] mag32(input logic [31:0] x);
      mag32 = x[31] ? (~x + 32'd1) : x;
   endfunction

   function automatic logic [SW-1:0] sterm(input logic [SW-1:0] m, input logic neg);
      sterm = neg ? (~m + SW'(1)) : m;
   endfunction

   // effective segment counts
   always_comb begin
      cx = CNTW'(x_count);
      cz = CNTW'(z_count);
      if (cx == '0) xc = CNTW'(1);
      else if (cx > CNTW'(MAX_SEGMENTS)) xc = CNTW'(MAX_SEGMENTS);
      else xc = cx;
      if (cz == '0) zc = CNTW'(1);
      else if (cz > CNTW'(MAX_SEGMENTS)) zc = CNTW'(MAX_SEGMENTS);
      else zc = cz;
      sum_n = (xc > zc) ? xc : zc;
   end

   // table writes
   assign idx_lw = LW'(in_idx_ff);
   assign idx_ok = (32'(in_idx_ff) < 32'(MAX_SEGMENTS));
   assign we_x   = (cmd.step == DP_WRITE) && idx_ok && !in_axis_ff;
   assign we_z   = (cmd.step == DP_WRITE) && idx_ok && in_axis_ff;

   // table read addresses
   always_comb begin
      raddr_x = x_seg_now_ff;
      raddr_z = z_seg_now_ff;
      if (cmd.step == DP_SUM_RD) begin
         raddr_x = cnt_ff[IW-1:0];
         raddr_z = cnt_ff[IW-1:0];
      end
      if (cmd.step == DP_XRD) raddr_x = x_seg_now_ff + IW'(1);
      if (cmd.step == DP_ZRD) raddr_z = z_seg_now_ff + IW'(1);
   end

   mpi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_xtab (
      .clock (clock),
      .we    (we_x),
      .waddr (idx_lw[IW-1:0]),
      .wdata (in_entry_ff),
      .raddr (raddr_x),
      .rdata (rd_x)
   );

   mpi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ztab (
      .clock (clock),
      .we    (we_z),
      .waddr (idx_lw[IW-1:0]),
      .wdata (in_entry_ff),
      .raddr (raddr_z),
      .rdata (rd_z)
   );

   // status back to the controller
   assign out_free = !rsp_valid_ff || rsp_tready;
   always_comb begin
      sts.req_new    = req_accept;
      sts.cmd        = in_cmd_ff;
      sts.run_active = run_active_ff;
      sts.adv_x      = !x_holding_ff && (run_time_ff > x_seg_end_ff);
      sts.x_last     = (CNTW'(x_seg_now_ff) + CNTW'(1)) >= xc;
      sts.adv_z      = (run_time_ff > z_seg_end_ff) && ((CNTW'(z_seg_now_ff) + CNTW'(1)) < zc);
      sts.sum_last   = (cnt_ff + CNTW'(1)) >= sum_n;
      sts.out_free   = out_free;
   end

   // time step and end of run
   assign next_in = {1'b0, run_time_ff} + (TIME_W + 1)'(time_step);
   assign last_in = next_in > {1'b0, z_total_ff};

   // segment start of the axis under evaluation
   assign rd_sel  = cmd.sel ? rd_z : rd_x;
   assign dur_sel = TIME_W'(rd_sel[DUR_W-1:0]);
   assign se_in   = cmd.sel ? z_seg_end_ff : x_seg_end_ff;
   assign diff_in = t_ff - start_ff;

   // run state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         run_time_ff   <= '0;
         x_total_ff    <= '0;
         z_total_ff    <= '0;
         x_seg_end_ff  <= '0;
         z_seg_end_ff  <= '0;
         x_seg_now_ff  <= '0;
         z_seg_now_ff  <= '0;
         x_holding_ff  <= 1'b0;
         run_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         // output register: refill on a finished tick, else drain when taken
         if (cmd.step == DP_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.step)
            DP_SUM_CLR: begin
               x_total_ff    <= '0;
               z_total_ff    <= '0;
               run_time_ff   <= '0;
               x_seg_now_ff  <= '0;
               z_seg_now_ff  <= '0;
               x_holding_ff  <= 1'b0;
               run_active_ff <= 1'b1;
               cnt_ff        <= '0;
            end
            DP_SUM_ACC: begin
               if (cnt_ff < xc) x_total_ff <= x_total_ff + TIME_W'(rd_x[DUR_W-1:0]);
               if (cnt_ff < zc) z_total_ff <= z_total_ff + TIME_W'(rd_z[DUR_W-1:0]);
               if (cnt_ff == '0) begin
                  x_seg_end_ff <= TIME_W'(rd_x[DUR_W-1:0]);
                  z_seg_end_ff <= TIME_W'(rd_z[DUR_W-1:0]);
               end
               cnt_ff <= cnt_ff + CNTW'(1);
            end
            DP_XADV: begin
               if (sts.adv_x && sts.x_last) x_holding_ff <= 1'b1;
            end
            DP_XRD:  x_seg_now_ff <= x_seg_now_ff + IW'(1);
            DP_XADD: x_seg_end_ff <= x_seg_end_ff + TIME_W'(rd_x[DUR_W-1:0]);
            DP_ZRD:  z_seg_now_ff <= z_seg_now_ff + IW'(1);
            DP_ZADD: z_seg_end_ff <= z_seg_end_ff + TIME_W'(rd_z[DUR_W-1:0]);
            DP_FINISH: begin
               if (out_free) begin
                  run_time_ff  <= next_in[TIME_W-1:0];
                  if (last_in) run_active_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // shared 32x32 multiplier operand
   assign v_mag = mag32(e_v_ff);
   assign a_mag = mag32(e_a_ff);
   always_comb begin
      unique case (cmd.step)
         DP_EV_M1: mul_a = v_mag;
         DP_EV_M2: mul_a = a_mag;
         DP_EV_M3: mul_a = prod_ff[31:0];
         DP_EV_M4: mul_a = ad_ff[63:32];
         default:  mul_a = '0;
      endcase
   end

   // rounding half up and saturation
   assign sum_rnd  = sum_ff + (SW'(1) << 20);
   assign vsum_rnd = vsum_ff + (VW'(1) << 15);
   always_comb begin
      if ((&sum_rnd[SW-1:68]) || !(|sum_rnd[SW-1:68])) pos_sat = sum_rnd[68:21];
      else if (sum_rnd[SW-1]) pos_sat = {1'b1, {(POS_W-1){1'b0}}};
      else pos_sat = {1'b0, {(POS_W-1){1'b1}}};
      if ((&vsum_rnd[VW-1:47]) || !(|vsum_rnd[VW-1:47])) vel_sat = vsum_rnd[47:16];
      else if (vsum_rnd[VW-1]) vel_sat = {1'b1, {(VEL_W-1){1'b0}}};
      else vel_sat = {1'b0, {(VEL_W-1){1'b1}}};
   end

   // request capture and evaluation datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff   <= req_tuser[1:0];
         in_axis_ff  <= req_tuser[2];
         in_idx_ff   <= req_tdata[3:0];
         in_entry_ff <= req_tdata[147:4];
      end
      prod_ff <= 64'(mul_a) * 64'(d_ff);
      unique case (cmd.step)
         DP_EV_START: begin
            e_pos_ff <= rd_sel[DUR_W +: POS_W];
            e_v_ff   <= rd_sel[DUR_W+POS_W +: VEL_W];
            e_a_ff   <= rd_sel[DUR_W+POS_W+VEL_W +: ACC_W];
            start_ff <= (se_in >= dur_sel) ? (se_in - dur_sel) : '0;
            t_ff     <= (!cmd.sel && x_holding_ff) ? x_total_ff : run_time_ff;
         end
         DP_EV_D: begin
            if (t_ff > start_ff) begin
               d_ff <= (diff_in > TIME_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : diff_in[31:0];
            end else begin
               d_ff <= '0;
            end
            sum_ff <= {{(SW-POS_W-21){e_pos_ff[POS_W-1]}}, e_pos_ff, 21'b0};
         end
         DP_EV_M2: sum_ff <= sum_ff + sterm(SW'(prod_ff) << 17, e_v_ff[VEL_W-1]);
         DP_EV_M3: ad_ff  <= prod_ff;
         DP_EV_M4: sum_ff <= sum_ff + sterm(SW'(prod_ff), e_a_ff[ACC_W-1]);
         DP_EV_M5: begin
            sum_ff  <= sum_ff + sterm(SW'(prod_ff) << 32, e_a_ff[ACC_W-1]);
            vsum_ff <= {{(VW-VEL_W-16){e_v_ff[VEL_W-1]}}, e_v_ff, 16'b0}
                       + (e_a_ff[ACC_W-1] ? (~VW'(ad_ff) + VW'(1)) : VW'(ad_ff));
         end
         DP_EV_RES: begin
            if (cmd.sel) begin
               pz_ff <= pos_sat;
               vz_ff <= vel_sat;
               az_ff <= e_a_ff;
            end else begin
               px_ff <= pos_sat;
               vx_ff <= vel_sat;
               ax_ff <= e_a_ff;
            end
         end
         DP_FINISH: begin
            if (out_free) begin
               o_time_ff <= (run_time_ff > TIME_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : run_time_ff[31:0];
               o_px_ff   <= px_ff;
               o_pz_ff   <= pz_ff;
               o_vx_ff   <= vx_ff;
               o_vz_ff   <= vz_ff;
               o_ax_ff   <= ax_ff;
               o_az_ff   <= az_ff;
               o_last_ff <= last_in;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {o_az_ff, o_ax_ff, o_vz_ff, o_vx_ff, o_pz_ff, o_px_ff, o_time_ff};

endmodule

[verif/mpi_checker.sv]
`timescale 1ns / 100ps

// watches both channels and the csr port, predicts every tick sample and
// compares it with what the block returns
module mpi_checker
   import mpi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // seg_index, seg_duration, seg_position, seg_velocity, seg_accel, pad
   input  logic [151:0] req_tdata,
   // cmd, axis
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // time_now, pos_x, pos_z, vel_x, vel_z, acc_x, acc_z
   input  logic [255:0] rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int unsigned  mismatches,
   output int unsigned  outstanding,
   output int unsigned  samples_seen
);

   typedef struct packed {
      logic [31:0] t_now;
      logic [47:0] px;
      logic [47:0] pz;
      logic [31:0] vx;
      logic [31:0] vz;
      logic [31:0] ax;
      logic [31:0] az;
      logic        last;
   } sample_t;

   sample_t sample_q[$];

   // register copies
   logic [31:0] step_size;
   logic [4:0]  x_cnt_reg, z_cnt_reg;

   // segment tables, index 0 x, 1 z
   logic [31:0] seg_dur [2][16];
   logic [47:0] seg_pos [2][16];
   logic [31:0] seg_vel [2][16];
   logic [31:0] seg_acc [2][16];

   // run state
   logic [39:0] clock_now, x_end, z_end;
   logic [63:0] x_sum, z_sum;
   int          x_now, z_now;
   logic        x_hold, running;

   assign outstanding = sample_q.size();

   function automatic int eff_count(input logic [4:0] c);
      if (c == 0) return 1;
      if (c > 16) return 16;
      return int'(c);
   endfunction

   // round half up by shift bits and clamp to a signed width
   function automatic logic [63:0] round_clamp(input logic signed [127:0] s,
                                               input int shift, input int width);
      logic signed [127:0] r, hi, lo;
      r  = (s + (128'sd1 <<< (shift - 1))) >>> shift;
      hi = (128'sd1 <<< (width - 1)) - 128'sd1;
      lo = -hi - 128'sd1;
      if (r > hi) r = hi;
      else if (r < lo) r = lo;
      return r[63:0];
   endfunction

   // position and velocity of one axis at time t inside the current segment
   task automatic axis_sample(input int ax, input int seg, input logic [39:0] seg_end,
                              input logic [63:0] t, output logic [47:0] p_out,
                              output logic [31:0] v_out);
      logic [63:0] seg_start, d;
      logic signed [127:0] dd, vd, ad, add, acc_sum;
      seg_start = (seg_end >= seg_dur[ax][seg]) ? 64'(seg_end - 40'(seg_dur[ax][seg]))
                                                : 64'd0;
      d = (t > seg_start) ? t - seg_start : 64'd0;
      if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      dd  = 128'($signed({1'b0, d[31:0]}));
      vd  = 128'($signed(seg_vel[ax][seg])) * dd;
      ad  = 128'($signed(seg_acc[ax][seg])) * dd;
      add = ad * dd;
      acc_sum = (128'($signed(seg_pos[ax][seg])) <<< 21) + (vd <<< 17) + add;
      p_out = 48'(round_clamp(acc_sum, 21, 48));
      v_out = 32'(round_clamp((128'($signed(seg_vel[ax][seg])) <<< 16) + ad, 16, 32));
   endtask

   // register writes
   always @(posedge clock) begin
      if (reset) begin
         step_size <= 32'd1311;
         x_cnt_reg <= 5'd4;
         z_cnt_reg <= 5'd4;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            REG_TIME_STEP: step_size <= csr_pwdata;
            REG_X_COUNT:   x_cnt_reg <= csr_pwdata[4:0];
            REG_Z_COUNT:   z_cnt_reg <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // request side: update state and queue the expected sample
   always @(posedge clock) begin
      logic [1:0]  cmd;
      int          ax, idx, xc, zc;
      logic [63:0] tx, next_t;
      sample_t     s;
      if (reset) begin
         clock_now = '0; x_end = '0; z_end = '0; x_sum = '0; z_sum = '0;
         x_now = 0; z_now = 0; x_hold = 1'b0; running = 1'b0;
      end else if (req_tvalid && req_tready) begin
         cmd = req_tuser[1:0];
         ax  = int'(req_tuser[2]);
         idx = int'(req_tdata[3:0]);
         xc  = eff_count(x_cnt_reg);
         zc  = eff_count(z_cnt_reg);
         if (cmd == CMD_LOAD) begin
            seg_dur[ax][idx] = req_tdata[35:4];
            seg_pos[ax][idx] = req_tdata[83:36];
            seg_vel[ax][idx] = req_tdata[115:84];
            seg_acc[ax][idx] = req_tdata[147:116];
         end else if (cmd == CMD_START) begin
            x_sum = '0;
            z_sum = '0;
            for (int i = 0; i < xc; i++) x_sum += 64'(seg_dur[0][i]);
            for (int i = 0; i < zc; i++) z_sum += 64'(seg_dur[1][i]);
            clock_now = '0;
            x_now = 0; z_now = 0;
            x_end = 40'(seg_dur[0][0]);
            z_end = 40'(seg_dur[1][0]);
            x_hold = 1'b0;
            running = 1'b1;
         end else if (cmd == CMD_TICK && running) begin
            // move past finished segments
            while (!x_hold && clock_now > x_end) begin
               if (x_now + 1 >= xc) x_hold = 1'b1;
               else begin
                  x_now++;
                  x_end = x_end + 40'(seg_dur[0][x_now]);
               end
            end
            while (clock_now > z_end && z_now + 1 < zc) begin
               z_now++;
               z_end = z_end + 40'(seg_dur[1][z_now]);
            end
            tx = x_hold ? x_sum : 64'(clock_now);
            s.t_now = (clock_now > 40'hFF_FFFF_FFFF >> 8) ? 32'hFFFF_FFFF : clock_now[31:0];
            axis_sample(0, x_now, x_end, tx, s.px, s.vx);
            axis_sample(1, z_now, z_end, 64'(clock_now), s.pz, s.vz);
            s.ax = seg_acc[0][x_now];
            s.az = seg_acc[1][z_now];
            next_t = 64'(clock_now) + 64'(step_size);
            s.last = (next_t > z_sum);
            clock_now = next_t[39:0];
            if (s.last) running = 1'b0;
            sample_q.push_back(s);
         end
      end
   end

   // result side: compare against the oldest expected sample
   always @(posedge clock) begin
      sample_t got, want;
      if (reset) begin
         mismatches   <= 0;
         samples_seen <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got.t_now = rsp_tdata[31:0];
         got.px    = rsp_tdata[79:32];
         got.pz    = rsp_tdata[127:80];
         got.vx    = rsp_tdata[159:128];
         got.vz    = rsp_tdata[191:160];
         got.ax    = rsp_tdata[223:192];
         got.az    = rsp_tdata[255:224];
         got.last  = rsp_tlast;
         samples_seen <= samples_seen + 1;
         if (sample_q.size() == 0) begin
            $display("%0t: unexpected sample, got %h", $time, got);
            mismatches <= mismatches + 1;
         end else begin
            want = sample_q.pop_front();
            if (got != want) begin
               $display("%0t: sample mismatch", $time);
               $display("   time_now exp %h got %h", want.t_now, got.t_now);
               $display("   pos_x    exp %h got %h", want.px, got.px);
               $display("   pos_z    exp %h got %h", want.pz, got.pz);
               $display("   vel_x    exp %h got %h", want.vx, got.vx);
               $display("   vel_z    exp %h got %h", want.vz, got.vz);
               $display("   acc_x    exp %h got %h", want.ax, got.ax);
               $display("   acc_z    exp %h got %h", want.az, got.az);
               $display("   last     exp %b got %b", want.last, got.last);
               mismatches <= mismatches + 1;
            end
         end
      end
   end

endmodule

[verif/tb_motion_profile_interpolator.sv]
`timescale 1ns / 100ps

module tb_motion_profile_interpolator;
   import mpi_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int unsigned  mismatches, outstanding, samples_seen;
   int           requests_sent;
   logic [31:0]  step_now;
   logic         calm = 1'b0;
   int           stall_left = 0;

   motion_profile_interpolator u_top (.*);

   mpi_checker u_chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #30_000_000;
      $display("timeout");
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                  : $urandom_range(20, 80);
      end
   end

   function automatic int pick_gap();
      if (calm) return 0;
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
   endfunction

   // one request, valid left high after the handshake
   task automatic send(input logic [1:0] cmd, input logic ax, input logic [3:0] idx,
                       input logic [31:0] dur, input logic [47:0] pos,
                       input logic [31:0] vel, input logic [31:0] acc);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {ax, cmd};
      req_tdata  <= {4'b0, acc, vel, pos, dur, idx};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_TIME_STEP) step_now = val;
   endtask

   function automatic logic [47:0] rand_pos();
      case ($urandom_range(0, 7))
         0: return 48'h7FFF_FFFF_FFFF;
         1: return 48'h8000_0000_0000;
         2: return {{16{1'b0}}, $urandom()};
         default: return 48'({$urandom(), $urandom()});
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 255) - 128;
         default: return $urandom();
      endcase
   endfunction

   // mostly a few time steps long so runs end in a sensible number of ticks
   function automatic logic [31:0] rand_dur();
      logic [31:0] span;
      span = (step_now > 32'h3FFF_FFFF) ? 32'h3FFF_FFFF : step_now;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'd0;
         default: return $urandom_range(0, 3 * span + 2);
      endcase
   endfunction

   task automatic load_random(input logic ax, input logic [3:0] idx);
      send(CMD_LOAD, ax, idx, rand_dur(), rand_pos(), rand_word(), rand_word());
   endtask

   task automatic tick();
      send(CMD_TICK, 1'($urandom_range(0, 1)), 4'($urandom()), $urandom(),
           rand_pos(), $urandom(), $urandom());
   endtask

   function automatic logic [31:0] rand_step();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return $urandom();
         default: return $urandom_range(1, 5000);
      endcase
   endfunction

   initial begin
      int n_ticks;
      step_now = 32'd1311;
      requests_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // directed: idle tick, unknown kind, extreme segments
      send(CMD_TICK, 1'b0, 4'd0, '0, '0, '0, '0);
      send(CMD_UNUSED, 1'b1, 4'd15, '1, '1, '1, '1);
      send(CMD_LOAD, 1'b0, 4'd0, 32'd0, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(CMD_LOAD, 1'b0, 4'd1, 32'hFFFF_FFFF, 48'h8000_0000_0000,
           32'h8000_0000, 32'h8000_0000);
      send(CMD_LOAD, 1'b0, 4'd2, 32'd2000, 48'd0, 32'd0, 32'h0010_0000);
      send(CMD_LOAD, 1'b0, 4'd3, 32'd1311, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
      send(CMD_LOAD, 1'b1, 4'd0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF,
           32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(CMD_LOAD, 1'b1, 4'd1, 32'hFFFF_FFFF, 48'h8000_0000_0000,
           32'h8000_0000, 32'h8000_0000);
      send(CMD_LOAD, 1'b1, 4'd2, 32'd5, 48'h0000_1234_5678, 32'h0000_8000, 32'hFFF0_0000);
      send(CMD_LOAD, 1'b1, 4'd3, 32'hFFFF_FFFF, 48'd0, 32'd0, 32'd0);
      send(CMD_START, 1'b0, 4'd0, '0, '0, '0, '0);
      repeat (3) tick();
      wait_idle();

      // largest step: time saturates and the run ends after a few ticks
      csr_write(REG_TIME_STEP, 32'hFFFF_FFFF);
      csr_write(REG_X_COUNT, 32'd0);
      csr_write(REG_Z_COUNT, 32'd4);
      send(CMD_START, 1'b0, 4'd0, '0, '0, '0, '0);
      repeat (6) tick();
      wait_idle();

      // fill every slot so any segment count is safe
      csr_write(REG_TIME_STEP, 32'd1311);
      for (int a = 0; a < 2; a++)
         for (int i = 0; i < 16; i++) load_random(a[0], i[3:0]);

      // random runs with fresh settings between them
      while (requests_sent < 560) begin
         wait_idle();
         calm = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 3))
            0: csr_write(REG_TIME_STEP, rand_step());
            1: csr_write(REG_X_COUNT, $urandom_range(0, 31));
            2: csr_write(REG_Z_COUNT, $urandom_range(0, 31));
            default: ;
         endcase
         repeat ($urandom_range(0, 5))
            load_random(1'($urandom_range(0, 1)), 4'($urandom()));
         send(CMD_START, 1'($urandom_range(0, 1)), 4'($urandom()), $urandom(), rand_pos(),
              $urandom(), $urandom());
         n_ticks = $urandom_range(2, 30);
         for (int k = 0; k < n_ticks; k++) begin
            case ($urandom_range(0, 19))
               0: load_random(1'($urandom_range(0, 1)), 4'($urandom()));
               1: send(CMD_UNUSED, 1'($urandom_range(0, 1)), 4'($urandom()), $urandom(),
                       rand_pos(), $urandom(), $urandom());
               2: send(CMD_START, 1'b0, 4'd0, '0, '0, '0, '0);
               default: tick();
            endcase
         end
      end
      calm = 1'b0;
      wait_idle();

      $display("requests sent %0d, samples checked %0d", requests_sent, samples_seen);
      $display("covered loads, starts, ticks, ignored kinds and count and step extremes");
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
